### rtl/wara_pkg.sv
`timescale 1ns / 1ps

package wara_pkg;

   localparam int IdBitsDefault = 32;
   localparam int IdW           = 32;
   localparam int IdxW          = 5;
   localparam int SeedW         = 32;
   localparam int CsrDataW      = 32;
   localparam int CsrIndexW     = 2;

   localparam logic [SeedW-1:0] LcgMul = 32'd1103515245;
   localparam logic [SeedW-1:0] LcgAdd = 32'd12345;

   localparam int LcgBit = 16;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_OWN_ID      = 2'd0,
      CSR_SEED_START  = 2'd1,
      CSR_FALLBACK    = 2'd2
   } csr_reg_type;

   typedef enum logic [1:0] {
      SLOT_ID   = 2'd0,
      SLOT_TIE  = 2'd1,
      SLOT_NONE = 2'd2
   } slot_type;

   typedef struct packed {
      logic func;
      logic sample_c;
      logic sample_b;
      logic sample_a;
   } req_item_type;

   typedef struct packed {
      logic     master;
      logic     finished;
      slot_type next_slot;
      logic     drive_low;
   } rsp_item_type;

endpackage

### rtl/wara_in_stage.sv
`timescale 1ns / 1ps

module wara_in_stage
   import wara_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  req_item_type req_item,
   input  logic         out_ready,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         advance;

   assign advance    = valid_ff && out_ready;
   assign req_tready = !valid_ff || advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

endmodule

### rtl/wara_core.sv
`timescale 1ns / 1ps

module wara_core
   import wara_pkg::*;
#(
   parameter int ID_BITS = IdBitsDefault
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata,
   input  logic                 step,
   input  req_item_type         item,
   output rsp_item_type         result
);

   localparam int PosW = $clog2(ID_BITS + 1);

   logic [IdW-1:0]   own_id_ff;
   logic             fallback_ff;
   logic [SeedW-1:0] seed_ff;
   logic [SeedW-1:0] seed_in;
   logic [PosW-1:0]  pos_ff;
   logic [PosW-1:0]  pos_in;
   logic             known_ff;
   logic             known_in;
   logic             master_ff;
   logic             master_in;
   logic             tie_slot_ff;
   logic             tie_slot_in;
   logic             tie_bit_ff;
   logic             tie_bit_in;

   logic [SeedW-1:0] lcg_next;
   logic [PosW-1:0]  pos_inc;
   logic             line_low;
   logic             mine_bit;
   logic             emit_bit;
   logic [IdxW-1:0]  mine_sh;
   logic [IdxW-1:0]  emit_sh;

   assign lcg_next = seed_ff * LcgMul + LcgAdd;
   assign pos_inc  = pos_ff + PosW'(1);
   assign line_low = (!item.sample_a && !item.sample_b) ||
                     (!item.sample_a && !item.sample_c) ||
                     (!item.sample_b && !item.sample_c);

   always_comb begin
      mine_sh  = IdxW'(ID_BITS - 1) - IdxW'(pos_ff);
      mine_bit = 1'b1;
      if (pos_ff < PosW'(ID_BITS)) begin
         mine_bit = own_id_ff[mine_sh];
      end
   end

   always_comb begin
      pos_in      = pos_ff;
      known_in    = known_ff;
      master_in   = master_ff;
      tie_slot_in = tie_slot_ff;
      tie_bit_in  = tie_bit_ff;
      seed_in     = seed_ff;
      if (!item.func) begin
         pos_in      = '0;
         known_in    = 1'b0;
         master_in   = 1'b0;
         tie_slot_in = 1'b0;
      end else if (known_ff) begin
         known_in = 1'b1;
      end else if (tie_slot_ff) begin
         if (tie_bit_ff && !item.sample_a) begin
            master_in = 1'b1;
         end else if (!tie_bit_ff && item.sample_a) begin
            master_in = 1'b0;
         end else begin
            master_in = fallback_ff;
         end
         known_in    = 1'b1;
         tie_slot_in = 1'b0;
      end else if (mine_bit && line_low) begin
         master_in = 1'b1;
         known_in  = 1'b1;
      end else begin
         pos_in = pos_inc;
         if (pos_inc == PosW'(ID_BITS)) begin
            seed_in     = lcg_next;
            tie_bit_in  = lcg_next[LcgBit];
            tie_slot_in = 1'b1;
         end
      end
   end

   always_comb begin
      emit_sh  = IdxW'(ID_BITS - 1) - IdxW'(pos_in);
      emit_bit = 1'b1;
      if (pos_in < PosW'(ID_BITS)) begin
         emit_bit = own_id_ff[emit_sh];
      end
   end

   always_comb begin
      if (known_in) begin
         result.drive_low = 1'b0;
         result.next_slot = SLOT_NONE;
         result.finished  = 1'b1;
         result.master    = master_in;
      end else if (tie_slot_in) begin
         result.drive_low = !tie_bit_in;
         result.next_slot = SLOT_TIE;
         result.finished  = 1'b0;
         result.master    = 1'b0;
      end else begin
         result.drive_low = !emit_bit;
         result.next_slot = SLOT_ID;
         result.finished  = 1'b0;
         result.master    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_id_ff   <= '0;
         fallback_ff <= 1'b0;
         seed_ff     <= '0;
         pos_ff      <= '0;
         known_ff    <= 1'b0;
         master_ff   <= 1'b0;
         tie_slot_ff <= 1'b0;
         tie_bit_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_OWN_ID: begin
                  own_id_ff <= csr_wdata;
               end
               CSR_SEED_START: begin
                  seed_ff <= csr_wdata;
               end
               CSR_FALLBACK: begin
                  fallback_ff <= csr_wdata[0];
               end
               default: begin
               end
            endcase
         end
         if (step) begin
            pos_ff      <= pos_in;
            known_ff    <= known_in;
            master_ff   <= master_in;
            tie_slot_ff <= tie_slot_in;
            tie_bit_ff  <= tie_bit_in;
            seed_ff     <= seed_in;
         end
      end
   end

   a_known_excludes_tie: assert property (@(posedge clock) disable iff (reset)
      !(known_ff && tie_slot_ff))
      else $error("Role decided while a tie-breaker slot is still pending.");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      (pos_ff <= PosW'(ID_BITS)) && (!tie_slot_ff || pos_ff == PosW'(ID_BITS)))
      else $error("Bit position out of step with the arbitration phase.");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      (step && !item.func) |=> (!known_ff && !tie_slot_ff && pos_ff == '0))
      else $error("Start transaction did not clear the arbitration state.");

endmodule

### rtl/wara_out_stage.sv
`timescale 1ns / 1ps

module wara_out_stage
   import wara_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type result,
   output logic         out_ready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output rsp_item_type rsp_item
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign out_ready  = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_item   = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (out_ready) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && out_ready) begin
         item_ff <= result;
      end
   end

endmodule

### rtl/wired_and_role_arbiter.sv
`timescale 1ns / 1ps

// Wired-AND role arbiter: each slot transaction (tuser high) carries three line samples and
// returns the drive level and kind of the next slot; a start transaction (tuser low) restarts
// arbitration. The identifier goes out MSB first, then one tie-breaker slot drawn from a
// 32-bit linear congruential generator, else the fallback register decides. One transaction
// is accepted every cycle unless the response side stalls; each passes the input register, a
// single step of decision logic and the generator multiply, and the result register. The
// user must write configuration only while no transaction is in flight; not enforced here.
module wired_and_role_arbiter
   import wara_pkg::*;
#(
   parameter int ID_BITS = IdBitsDefault
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // sample_a, sample_b, sample_c, zero fill
   input  logic                 req_tuser,   // func
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // drive_low, next_slot[1:0], finished, master, zero fill
   input  logic                 csr_we,
   input  logic [CsrIndexW-1:0] csr_index,
   input  logic [CsrDataW-1:0]  csr_wdata
);

   req_item_type req_item;
   req_item_type item;
   rsp_item_type result;
   rsp_item_type rsp_item;
   logic         item_valid;
   logic         out_ready;
   logic         step;

   assign req_item.func     = req_tuser;
   assign req_item.sample_a = req_tdata[0];
   assign req_item.sample_b = req_tdata[1];
   assign req_item.sample_c = req_tdata[2];

   assign step = item_valid && out_ready;

   assign rsp_tdata = {3'b000, rsp_item.master, rsp_item.finished,
                       rsp_item.next_slot, rsp_item.drive_low};

   wara_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .out_ready  (out_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   wara_core #(
      .ID_BITS (ID_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (step),
      .item      (item),
      .result    (result)
   );

   wara_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .result     (result),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

endmodule
